// ===== design/mee_pkg.sv =====
// Package with the shared types and constants of the Mandelbrot escape-time block.
`default_nettype none
package mee_pkg;
	localparam int CFG_W   = 32;
	localparam int LIMIT_W = 16;
	localparam int REGIDX_W = 3;

	localparam logic [REGIDX_W-1:0] REG_X_MIN      = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_Y_MIN      = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_X_STEP     = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_Y_STEP     = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_ITER_LIMIT = 3'd4;

	localparam logic [CFG_W-1:0]   RST_X_MIN      = 32'hE000_0000;
	localparam logic [CFG_W-1:0]   RST_Y_MIN      = 32'hE000_0000;
	localparam logic [CFG_W-1:0]   RST_X_STEP     = 32'd262144;
	localparam logic [CFG_W-1:0]   RST_Y_STEP     = 32'd262144;
	localparam logic [LIMIT_W-1:0] RST_ITER_LIMIT = 16'd32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UV_MUL,
		ST_UV_SAT,
		ST_V_ADD,
		ST_SQ_LAUNCH,
		ST_SQ_MUL,
		ST_SQ_SAT
	} state_t;
endpackage
`default_nettype wire

// ===== design/mee_cell.sv =====
// One multiplier cell of the chain: shifts the incoming sum up one digit and adds a digit product.
`default_nettype none
module mee_cell #(
	parameter int MAG_W = 36,
	parameter int DIG_W = 18
) (
	input  wire logic                     clk,
	input  wire logic [MAG_W+2*DIG_W-1:0] acc_in,
	input  wire logic [MAG_W-1:0]         a_in,
	input  wire logic [2*DIG_W-1:0]       b_in,
	output logic      [MAG_W+2*DIG_W-1:0] acc_s1,
	output logic      [MAG_W-1:0]         a_s1,
	output logic      [2*DIG_W-1:0]       b_s1
);
	localparam int ACC_W = MAG_W + 2 * DIG_W;

	logic [MAG_W+DIG_W-1:0] digit_prod;

	assign digit_prod = a_in * b_in[2*DIG_W-1:DIG_W];

	always_ff @(posedge clk) begin
		acc_s1 <= (acc_in << DIG_W) + ACC_W'(digit_prod);
		a_s1   <= a_in;
		b_s1   <= b_in << DIG_W;
	end
endmodule
`default_nettype wire

// ===== design/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block: point forming, iteration control and the cell chains.
// A transaction is taken when start is high and busy is low, and its result appears on the
// output ports for one cycle with done high, once the pixel has escaped or reached the
// iteration limit; the block takes no new pixel until then. Each iteration uses the two-cell
// multiplier chains first for z_re * z_im and then for the two squares.
// The receiver cannot stall, so the result must be captured in the cycle that done is high.
`default_nettype none
module mandelbrot_escape_time #(
	parameter int COORD_FRAC_BITS = 28,
	parameter int INDEX_BITS      = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [mee_pkg::REGIDX_W-1:0]  wr_index,
	input  wire logic [mee_pkg::CFG_W-1:0]     wr_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [INDEX_BITS-1:0]         column,
	input  wire logic [INDEX_BITS-1:0]         row,
	output logic                               done,
	output logic      [INDEX_BITS-1:0]         out_column,
	output logic      [INDEX_BITS-1:0]         out_row,
	output logic      [mee_pkg::LIMIT_W-1:0]   iterations,
	output logic                               inside_res
);
	import mee_pkg::*;

	localparam int W      = COORD_FRAC_BITS + 8;
	localparam int DIG_W  = (W + 1) / 2;
	localparam int ACC_W  = W + 2 * DIG_W;
	localparam int CP_W   = CFG_W + INDEX_BITS + 1;
	localparam int SUM_W  = CP_W + 1;
	localparam int EW     = ((W > SUM_W) ? W : SUM_W) + 1;

	localparam logic signed [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [EW-1:0] EMAX = EW'(SMAX);
	localparam logic signed [EW-1:0] EMIN = EW'(SMIN);
	localparam logic [W:0]           FOUR = (W+1)'(1) << (COORD_FRAC_BITS + 2);

	state_t state_q, state_d;

	logic signed [CFG_W-1:0]   x_min_q, y_min_q, x_step_q, y_step_q;
	logic        [LIMIT_W-1:0] limit_q;
	logic        [INDEX_BITS-1:0] col_q, row_q;
	logic signed [W-1:0]       cx_q, cy_q, u_q, v_q, u2_q, v2_q, pm_q;
	logic        [LIMIT_W-1:0] k_q;
	logic                      neg_q;
	logic                      done_q, inside_q;
	logic        [LIMIT_W-1:0] iter_q;
	logic        [INDEX_BITS-1:0] ocol_q, orow_q;

	logic                      accept, escaped, finish;
	logic signed [CP_W-1:0]    xprod, yprod;
	logic signed [EW-1:0]      cx_full, cy_full;
	logic signed [W-1:0]       cx_sat, cy_sat, u_new;
	logic        [W-1:0]       u_mag, v_mag;
	logic        [W:0]         mag_sum;

	logic [ACC_W-1:0]   acc0 [2];
	logic [ACC_W-1:0]   acc1 [2];
	logic [W-1:0]       a0   [2];
	logic [W-1:0]       a1   [2];
	logic [2*DIG_W-1:0] b0   [2];
	logic [2*DIG_W-1:0] b1   [2];
	logic [W-1:0]       lane_a [2];
	logic [2*DIG_W-1:0] lane_b [2];

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = (W+1)'(a) + (W+1)'(b);
		if (s > (W+1)'(SMAX))
			return SMAX;
		else if (s < (W+1)'(SMIN))
			return SMIN;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] clamp_e(input logic signed [EW-1:0] s);
		if (s > EMAX)
			return SMAX;
		else if (s < EMIN)
			return SMIN;
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] mul_sat(input logic [ACC_W-1:0] p,
			input logic neg, input logic full_shift);
		logic [ACC_W-1:0] r;
		logic             big;
		r   = full_shift ? (p >> COORD_FRAC_BITS) : (p >> (COORD_FRAC_BITS - 1));
		big = r > ACC_W'(SMAX);
		if (neg)
			return big ? SMIN : -$signed(r[W-1:0]);
		return big ? SMAX : $signed(r[W-1:0]);
	endfunction

	assign accept = start && !busy;

	assign xprod   = x_step_q * $signed({1'b0, column});
	assign yprod   = y_step_q * $signed({1'b0, row});
	assign cx_full = EW'(x_min_q) + EW'(xprod);
	assign cy_full = EW'(y_min_q) + EW'(yprod);
	assign cx_sat  = clamp_e(cx_full);
	assign cy_sat  = clamp_e(cy_full);

	assign u_mag   = u_q[W-1] ? W'(-u_q) : W'(u_q);
	assign v_mag   = v_q[W-1] ? W'(-v_q) : W'(v_q);
	assign mag_sum = (W+1)'(u2_q) + (W+1)'(v2_q);
	assign escaped = mag_sum >= FOUR;
	assign finish  = escaped || (k_q >= limit_q);
	assign u_new   = sat_add(sat_add(u2_q, -v2_q), cx_q);

	assign lane_a[0] = u_mag;
	assign lane_a[1] = v_mag;
	assign lane_b[0] = (state_q == ST_CHECK) ? (2*DIG_W)'(v_mag) : (2*DIG_W)'(u_mag);
	assign lane_b[1] = (2*DIG_W)'(v_mag);

	for (genvar g = 0; g < 2; g++) begin : g_lane
		mee_cell #(.MAG_W(W), .DIG_W(DIG_W)) u_cell0 (
			.clk   (clk),
			.acc_in('0),
			.a_in  (lane_a[g]),
			.b_in  (lane_b[g]),
			.acc_s1(acc0[g]),
			.a_s1  (a0[g]),
			.b_s1  (b0[g])
		);
		mee_cell #(.MAG_W(W), .DIG_W(DIG_W)) u_cell1 (
			.clk   (clk),
			.acc_in(acc0[g]),
			.a_in  (a0[g]),
			.b_in  (b0[g]),
			.acc_s1(acc1[g]),
			.a_s1  (a1[g]),
			.b_s1  (b1[g])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (accept) state_d = ST_CHECK;
			ST_CHECK:     state_d = finish ? ST_IDLE : ST_UV_MUL;
			ST_UV_MUL:    state_d = ST_UV_SAT;
			ST_UV_SAT:    state_d = ST_V_ADD;
			ST_V_ADD:     state_d = ST_SQ_LAUNCH;
			ST_SQ_LAUNCH: state_d = ST_SQ_MUL;
			ST_SQ_MUL:    state_d = ST_SQ_SAT;
			ST_SQ_SAT:    state_d = ST_CHECK;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			x_min_q  <= RST_X_MIN;
			y_min_q  <= RST_Y_MIN;
			x_step_q <= RST_X_STEP;
			y_step_q <= RST_Y_STEP;
			limit_q  <= RST_ITER_LIMIT;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_CHECK) && finish;
			if (wr_en) begin
				case (wr_index)
					REG_X_MIN:      x_min_q  <= wr_data;
					REG_Y_MIN:      y_min_q  <= wr_data;
					REG_X_STEP:     x_step_q <= wr_data;
					REG_Y_STEP:     y_step_q <= wr_data;
					REG_ITER_LIMIT: limit_q  <= wr_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q <= column;
				row_q <= row;
				cx_q  <= cx_sat;
				cy_q  <= cy_sat;
				u_q   <= '0;
				v_q   <= '0;
				u2_q  <= '0;
				v2_q  <= '0;
				k_q   <= '0;
			end
			ST_CHECK: begin
				neg_q <= u_q[W-1] ^ v_q[W-1];
				if (finish) begin
					ocol_q   <= col_q;
					orow_q   <= row_q;
					iter_q   <= k_q;
					inside_q <= !escaped;
				end else begin
					u_q <= u_new;
				end
			end
			ST_UV_SAT: pm_q <= mul_sat(acc1[0], neg_q, 1'b0);
			ST_V_ADD:  v_q  <= sat_add(pm_q, cy_q);
			ST_SQ_SAT: begin
				u2_q <= mul_sat(acc1[0], 1'b0, 1'b1);
				v2_q <= mul_sat(acc1[1], 1'b0, 1'b1);
				k_q  <= k_q + LIMIT_W'(1);
			end
			default: ;
		endcase
	end

	assign done       = done_q;
	assign out_column = ocol_q;
	assign out_row    = orow_q;
	assign iterations = iter_q;
	assign inside_res = inside_q;
endmodule
`default_nettype wire

// ===== design/mee_checker.sv =====
// Port-level checker for the Mandelbrot escape-time block, bound to the top level.
`default_nettype none
module mee_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Block did not go busy after taking a transaction.");

	a_done_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe raised while the block is still busy.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted longer than one cycle.");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Block went idle without returning a result.");
endmodule

bind mandelbrot_escape_time mee_checker u_mee_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
`default_nettype wire
